[hw/rtl/ffbp_pkg.sv]
// Shared types and constants of the first-fit bin packer.
`timescale 1ns / 1ps

package ffbp_pkg;

    localparam int SIZE_W = 16;
    localparam int IDX_W  = 4;
    localparam int REM_W  = 16;

    localparam logic [SIZE_W-1:0] BIN_CAP_RESET = 16'd1000;

    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] item_size;
    } ffbp_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic [REM_W-1:0] remaining;
        logic             no_fit;
    } ffbp_out_t;

    // Search token handed from cell to cell; on clear, size carries the fill capacity.
    typedef struct packed {
        logic              valid;
        logic              clear;
        logic              found;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  idx;
        logic [REM_W-1:0]  rem;
    } ffbp_tok_t;

endpackage

[hw/rtl/first_fit_bin_packer.sv]
// First-fit bin packer: launches requests into a chain of bin cells and buffers results.
//
// Each request travels down a row of NUM_BINS cells, one bin per cell and one cell per
// cycle. A place request is taken by the first bin whose remaining capacity is at least
// the item size, which is the lowest-numbered such bin; later cells pass it along. A clear
// request loads the configured capacity into every bin as it passes. A request is accepted
// only while no other is in flight: in_stall stays high from acceptance until the result
// is loaded into the output register, which out_stall can delay by holding the result in
// the pending register. A request that fits no bin returns no_fit and changes nothing. A
// cfg_data write takes effect at the next clear. The output register lets a new request
// start while a result still waits to be taken.
`timescale 1ns / 1ps

module first_fit_bin_packer
    import ffbp_pkg::*;
#(
    parameter int NUM_BINS  = 16,
    parameter int CAP_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ffbp_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ffbp_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    logic              busy_reg;
    logic              busy_next;
    logic [SIZE_W-1:0] cap_reg;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    ffbp_out_t         pend_reg;
    ffbp_out_t         pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    ffbp_out_t         out_reg;
    ffbp_out_t         out_next;

    ffbp_tok_t chain_tok [NUM_BINS+1];
    ffbp_tok_t launch_tok;
    ffbp_tok_t end_tok;
    ffbp_out_t end_res;

    logic in_accept;
    logic out_take;
    logic out_free;
    logic load_out;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg;
    assign in_accept = in_valid && !busy_reg;

    always_comb
    begin
        launch_tok.valid = in_accept;
        launch_tok.clear = (in_data.req_type == REQ_CLEAR);
        launch_tok.found = 1'b0;
        launch_tok.size  = (in_data.req_type == REQ_CLEAR) ? cap_reg : in_data.item_size;
        launch_tok.idx   = '0;
        launch_tok.rem   = '0;
    end

    assign chain_tok[0] = launch_tok;

    for (genvar i = 0; i < NUM_BINS; i++)
    begin : g_cell
        ffbp_cell #(
            .CAP_WIDTH (CAP_WIDTH),
            .BIN_ID    (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain_tok[i]),
            .tok_out (chain_tok[i+1])
        );
    end

    assign end_tok = chain_tok[NUM_BINS];

    always_comb
    begin
        end_res.bin_index = end_tok.idx;
        end_res.remaining = end_tok.rem;
        end_res.no_fit    = !end_tok.clear && !end_tok.found;
    end

    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_take;
    assign load_out = out_free && (pend_valid_reg || end_tok.valid);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_take;
        out_next        = out_reg;
        busy_next       = busy_reg;

        if (in_accept)
        begin
            busy_next = 1'b1;
        end

        if (pend_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
        end
        else if (end_tok.valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_next       = end_res;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_next       = end_res;
            end
        end

        if (load_out)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cap_reg        <= BIN_CAP_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_busy_clears_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(load_out))
        else $error("busy dropped without a result reaching the output register");

    a_one_result_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_valid_reg && end_tok.valid))
        else $error("chain delivered a result while another is pending");

    a_result_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        end_tok.valid |-> busy_reg)
        else $error("chain delivered a result with no request in flight");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> busy_reg && !in_accept)
        else $error("request accepted while another is in flight");

endmodule

[hw/rtl/ffbp_cell.sv]
// One bin of the packer chain: holds its remaining capacity and passes the token on.
`timescale 1ns / 1ps

module ffbp_cell
    import ffbp_pkg::*;
#(
    parameter int CAP_WIDTH = 16,
    parameter int BIN_ID    = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ffbp_tok_t tok_in,
    output ffbp_tok_t tok_out
);

    localparam int CW = (CAP_WIDTH > SIZE_W) ? CAP_WIDTH : SIZE_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(BIN_ID);

    logic [CAP_WIDTH-1:0] cap_reg;
    logic [CAP_WIDTH-1:0] cap_next;
    ffbp_tok_t            tok_reg;
    ffbp_tok_t            tok_next;
    logic [CW-1:0]        cap_ext;
    logic [CW-1:0]        size_ext;
    logic [CW-1:0]        diff;
    logic                 fits;

    assign cap_ext  = CW'(cap_reg);
    assign size_ext = CW'(tok_in.size);
    assign diff     = cap_ext - size_ext;
    // first bin along the chain that can take the item claims it
    assign fits     = tok_in.valid && !tok_in.clear && !tok_in.found && (cap_ext >= size_ext);

    always_comb
    begin
        tok_next = tok_in;
        cap_next = cap_reg;
        if (tok_in.valid && tok_in.clear)
        begin
            cap_next = CAP_WIDTH'(tok_in.size);
        end
        else if (fits)
        begin
            cap_next       = diff[CAP_WIDTH-1:0];
            tok_next.found = 1'b1;
            tok_next.idx   = MY_IDX;
            tok_next.rem   = REM_W'(diff[CAP_WIDTH-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_WIDTH'(BIN_CAP_RESET);
            tok_reg <= '0;
        end
        else
        begin
            cap_reg <= cap_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
